>>> rtl/rpnc_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Holds opcodes, status codes, state enums and control structs.
// Depends on nothing; every other file in rtl imports it.
package rpnc_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 48;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_RND,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic ack;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } md_rsp_t;

endpackage

>>> rtl/rpnc_cell.sv
// One stack entry of the RPN calculator's shift stack.
// Takes the neighbor above on push, the neighbor below on pop.
// Depends on rpnc_pkg.
module rpnc_cell #(
  parameter int VALUE_WIDTH = rpnc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  rpnc_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_WIDTH-1:0] from_upper,
  input  logic [VALUE_WIDTH-1:0] from_lower,
  output logic [VALUE_WIDTH-1:0] q
);
  import rpnc_pkg::*;

  logic [VALUE_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= from_upper;
    end else if (ctl.pop) begin
      data_r <= from_lower;
    end
  end

  assign q = data_r;

endmodule

>>> rtl/rpnc_muldiv.sv
// Iterative magnitude multiply then rounded divide for the RPN calculator.
// Shift-add multiply, one bit a cycle, then restoring divide, one bit a cycle.
// Depends on rpnc_pkg.
module rpnc_muldiv #(
  parameter int VALUE_WIDTH = rpnc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpnc_pkg::md_req_t      req,
  input  logic [VALUE_WIDTH-1:0] op_a,
  input  logic [VALUE_WIDTH-1:0] op_b,
  output rpnc_pkg::md_rsp_t      rsp,
  output logic [VALUE_WIDTH-1:0] mag
);
  import rpnc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);
  localparam logic [W-1:0]  HUNDRED = W'(100);
  localparam logic [PW:0]   VMAX_X  = (PW+1)'({1'b0, {(W-1){1'b1}}});
  localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

  md_state_t      st_r, st_nxt;
  logic [CW-1:0]  cnt_r;
  logic [PW-1:0]  mcand_r;
  logic [W-1:0]   mplier_r;
  logic [PW-1:0]  prod_r;
  logic [W-1:0]   dvsr_r;
  logic [W-1:0]   rem_r;
  logic [PW-1:0]  quo_r;
  logic [PW:0]    qfin_r;

  logic [W:0]     rem_sh;
  logic           rem_ge;
  logic [W:0]     rem_sub;
  logic           rnd;

  assign rem_sh  = {rem_r, prod_r[PW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvsr_r};
  assign rem_sub = rem_sh - {1'b0, dvsr_r};
  assign rnd     = {rem_r, 1'b0} >= {1'b0, dvsr_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      MD_IDLE: if (req.start) st_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == '0) st_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == '0) st_nxt = MD_RND;
      MD_RND:  st_nxt = MD_DONE;
      MD_DONE: if (req.ack) st_nxt = MD_IDLE;
      default: st_nxt = MD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.busy = 1'b1;
    rsp.done = 1'b0;
    rsp.sat  = qfin_r > VMAX_X;
    case (st_r)
      MD_IDLE: rsp.busy = 1'b0;
      MD_DONE: rsp.done = 1'b1;
      default: rsp.busy = 1'b1;
    endcase
  end

  assign mag = qfin_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      MD_IDLE: begin
        mcand_r  <= {{W{1'b0}}, op_a};
        mplier_r <= req.is_div ? HUNDRED : op_b;
        dvsr_r   <= req.is_div ? op_b : HUNDRED;
        prod_r   <= '0;
        cnt_r    <= MUL_LAST;
      end
      MD_MUL: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= {mcand_r[PW-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[W-1:1]};
        if (cnt_r == '0) begin
          cnt_r <= DIV_LAST;
          rem_r <= '0;
          quo_r <= '0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      MD_DIV: begin
        // shift in the next numerator bit, subtract when it fits
        rem_r  <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        quo_r  <= {quo_r[PW-2:0], rem_ge};
        prod_r <= {prod_r[PW-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
      end
      MD_RND: begin
        qfin_r <= {1'b0, quo_r} + {{PW{1'b0}}, rnd};
      end
      default: begin
        qfin_r <= qfin_r;
      end
    endcase
  end

endmodule

>>> rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: handshake, decode, shift stack.
// Depends on rpnc_pkg, rpnc_cell and rpnc_muldiv.
//
// Postfix calculator on signed fixed-point hundredths. Each input beat is a
// push or an add, subtract, multiply or divide of second-from-top OP top; each
// input beat yields exactly one output beat carrying the new top (0 when the
// stack is empty), the entry count and a status (ok, underflow, overflow,
// divide by zero, saturated). On any error the stack is left unchanged.
// Push, add, subtract, errors and unused opcodes are handled directly: the output
// beat is registered the cycle after the input beat. Multiply and divide run
// in the shared iterative unit: a launch, a shift-add multiply, a restoring
// divide, a rounding step and a handoff that waits for a free output register.
// The stack is a row of STACK_DEPTH cells that shift down on push and up on
// pop. One item is in flight at a time; the input is ready only while the
// output register is empty or its beat is taken in the same cycle.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rpnc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_opcode,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_top_value,
  output logic [4:0]                    out_stack_count,
  output logic [2:0]                    out_status
);
  import rpnc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]    VMAX_X  = {2'b00, {(W-1){1'b1}}};
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  function automatic logic [W-1:0] from_sm(input logic neg, input logic [W:0] m);
    logic [W:0] n;
    n = neg ? (~m + 1'b1) : m;
    return n[W-1:0];
  endfunction

  top_state_t    st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic          md_neg_r;
  logic          out_valid_r;
  logic [W-1:0]  out_top_r;
  logic [CW-1:0] out_cnt_r;
  logic [2:0]    out_status_r;

  logic [W-1:0]  cell_q [STACK_DEPTH];
  cell_ctl_t     ctl;

  md_req_t       md_req;
  md_rsp_t       md_rsp;
  logic [W-1:0]  md_mag;

  // --- operand decode: A is second from top, B is top -----------------------
  logic [W-1:0]  opa, opb, ma, mb;
  logic          na, nb, nb2, nr;
  logic [W:0]    mr;
  logic          as_sat;
  logic [W-1:0]  as_res;

  assign opa = cell_q[1];
  assign opb = cell_q[0];
  assign na  = opa[W-1];
  assign nb  = opb[W-1];
  assign ma  = na ? (~opa + 1'b1) : opa;
  assign mb  = nb ? (~opb + 1'b1) : opb;
  assign nb2 = nb ^ (in_opcode == OP_SUB);

  // sign-magnitude add: subtract just flips the sign of B
  always_comb begin
    if (na == nb2) begin
      mr = {1'b0, ma} + {1'b0, mb};
      nr = na;
    end else if (ma >= mb) begin
      mr = {1'b0, ma} - {1'b0, mb};
      nr = na;
    end else begin
      mr = {1'b0, mb} - {1'b0, ma};
      nr = nb2;
    end
  end

  assign as_sat = mr > VMAX_X;
  assign as_res = from_sm(nr, mr);

  // --- handshake -------------------------------------------------------------
  logic out_free, accept, enough, div_zero, go_md;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == T_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign enough   = cnt_r >= TWO_C;
  assign div_zero = (in_opcode == OP_DIV) && (mb == '0);
  assign go_md    = accept && enough && !div_zero &&
                    ((in_opcode == OP_MUL) || (in_opcode == OP_DIV));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE:  if (go_md) st_nxt = T_WAIT;
      T_WAIT:  if (md_rsp.done && out_free) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // outputs of the control: emit a result beat, move the stack, drive the unit
  logic          emit;
  logic [2:0]    emit_status;
  logic [W-1:0]  pop_data;

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    ctl         = '0;
    pop_data    = as_res;
    md_req      = '0;
    md_req.is_div = (in_opcode == OP_DIV);
    case (st_r)
      T_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_PUSH: begin
              emit = 1'b1;
              if (cnt_r >= DEPTH_C) emit_status = ST_OVER;
              else if (in_value == VMIN) emit_status = ST_SAT;
              else ctl.push = 1'b1;
            end
            OP_ADD, OP_SUB: begin
              emit = 1'b1;
              if (!enough) emit_status = ST_UNDER;
              else if (as_sat) emit_status = ST_SAT;
              else ctl.pop = 1'b1;
            end
            OP_MUL, OP_DIV: begin
              if (!enough) begin
                emit        = 1'b1;
                emit_status = ST_UNDER;
              end else if (div_zero) begin
                emit        = 1'b1;
                emit_status = ST_DIVZ;
              end else begin
                md_req.start = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      T_WAIT: begin
        pop_data = from_sm(md_neg_r, {1'b0, md_mag});
        if (md_rsp.done && out_free) begin
          emit       = 1'b1;
          md_req.ack = 1'b1;
          if (md_rsp.sat) emit_status = ST_SAT;
          else ctl.pop = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // value and count after this beat
  logic [CW-1:0] cnt_nxt;
  logic [W-1:0]  top_nxt;

  always_comb begin
    if (ctl.push) begin
      cnt_nxt = cnt_r + 1'b1;
      top_nxt = in_value;
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
      top_nxt = pop_data;
    end else begin
      cnt_nxt = cnt_r;
      top_nxt = (cnt_r == '0) ? '0 : cell_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // hold the result payload until the next beat replaces it
  always_ff @(posedge clk) begin
    if (emit) begin
      out_top_r    <= top_nxt;
      out_cnt_r    <= cnt_nxt;
      out_status_r <= emit_status;
    end
    if (md_req.start) md_neg_r <= na ^ nb;
  end

  logic [CW+4:0] cnt_wide;
  assign cnt_wide        = {5'b0, out_cnt_r};
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_count = cnt_wide[4:0];
  assign out_status      = out_status_r;

  // --- stack: a row of cells, top at index 0 --------------------------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] up_d, lo_d;
    if (i == 0) begin : g_top
      assign up_d = in_value;
      assign lo_d = pop_data;
    end else if (i == STACK_DEPTH - 1) begin : g_bot
      assign up_d = cell_q[i-1];
      assign lo_d = cell_q[i];
    end else begin : g_mid
      assign up_d = cell_q[i-1];
      assign lo_d = cell_q[i+1];
    end
    rpnc_cell #(.VALUE_WIDTH(W)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_upper (up_d),
      .from_lower (lo_d),
      .q          (cell_q[i])
    );
  end

  rpnc_muldiv #(.VALUE_WIDTH(W)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (ma),
    .op_b  (mb),
    .rsp   (md_rsp),
    .mag   (md_mag)
  );

  // --- assertions ------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("stack count beyond depth");

  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !md_rsp.busy) else $error("input ready while unit busy");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_status != ST_OK) |=> cnt_r == $past(cnt_r))
    else $error("stack moved on error");

endmodule
